// File: src/ppm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants for the posture PID mixer
// Field widths, register codes, reset values and the fixed position offsets.
// ----------------------------------------------------------------------------
package ppm_pkg;

    // Field and register widths
    localparam int ATT_W      = 13;
    localparam int POS_IN_W   = 16;
    localparam int X_W        = 17;
    localparam int D_W        = 18;
    localparam int GAIN_W     = 24;
    localparam int TICK_W     = 16;
    localparam int LIM_W      = 10;
    localparam int VEL_W      = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int NTERMS     = 6;
    localparam int NPOS       = 4;

    // Parameter defaults
    localparam int SUM_BITS_DEF       = 32;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATT_KP     = 4'd0,
        CFG_ATT_KI     = 4'd1,
        CFG_ATT_KD     = 4'd2,
        CFG_POS_KP     = 4'd3,
        CFG_POS_KI     = 4'd4,
        CFG_POS_KD     = 4'd5,
        CFG_HOLD_TICKS = 4'd6,
        CFG_VEL_LIMIT  = 4'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [GAIN_W-1:0] ATT_KP_RST     = 24'd1966080;
    localparam logic [GAIN_W-1:0] ATT_KI_RST     = 24'd6554;
    localparam logic [GAIN_W-1:0] ATT_KD_RST     = 24'd65536;
    localparam logic [GAIN_W-1:0] POS_KP_RST     = 24'd32768;
    localparam logic [GAIN_W-1:0] POS_KI_RST     = 24'd0;
    localparam logic [GAIN_W-1:0] POS_KD_RST     = 24'd655;
    localparam logic [TICK_W-1:0] HOLD_TICKS_RST = 16'd500;
    localparam logic [LIM_W-1:0]  VEL_LIMIT_RST  = 10'd200;

    // Mounting offsets added to the raw actuator positions
    typedef logic signed [X_W-1:0] t_pos;
    localparam t_pos POS_OFFSET [NPOS] = '{-17'sd4910, 17'sd200, 17'sd200, -17'sd200};

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

endpackage

// File: src/ppm_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_term: one PID term
// Forms kp*x + kd*d + ki*s exactly, at the fractional scale of the gains.
// ----------------------------------------------------------------------------
module ppm_term
    import ppm_pkg::*;
#(
    parameter int SUM_BITS = SUM_BITS_DEF
) (
    input  logic [GAIN_W-1:0]                 i_kp,
    input  logic [GAIN_W-1:0]                 i_ki,
    input  logic [GAIN_W-1:0]                 i_kd,
    input  logic signed [X_W-1:0]             i_x,
    input  logic signed [D_W-1:0]             i_d,
    input  logic signed [SUM_BITS-1:0]        i_s,
    output logic signed [SUM_BITS+GAIN_W+2:0] o_term
);

    localparam int TERM_W = SUM_BITS + GAIN_W + 3;

    logic signed [GAIN_W:0]          kp_s;
    logic signed [GAIN_W:0]          ki_s;
    logic signed [GAIN_W:0]          kd_s;
    logic signed [GAIN_W+X_W:0]      p_p;
    logic signed [GAIN_W+D_W:0]      p_d;
    logic signed [GAIN_W+SUM_BITS:0] p_i;

    // Gains are unsigned: widen with a zero sign bit
    assign kp_s = {1'b0, i_kp};
    assign ki_s = {1'b0, i_ki};
    assign kd_s = {1'b0, i_kd};

    // Three independent products, then one three-input add
    assign p_p = kp_s * i_x;
    assign p_d = kd_s * i_d;
    assign p_i = ki_s * i_s;

    assign o_term = TERM_W'(p_p) + TERM_W'(p_d) + TERM_W'(p_i);

endmodule

// File: src/ppm_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_mix: one actuator velocity channel
// Mixes pitch, roll and position terms, floors to whole units and clamps; forces zero while held.
// ----------------------------------------------------------------------------
module ppm_mix
    import ppm_pkg::*;
#(
    parameter int TERM_W    = SUM_BITS_DEF + GAIN_W + 3,
    parameter int FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic signed [TERM_W-1:0] i_pitch,
    input  logic signed [TERM_W-1:0] i_roll,
    input  logic signed [TERM_W-1:0] i_pos,
    input  logic                     i_pitch_neg,
    input  logic                     i_roll_neg,
    input  logic [LIM_W-1:0]         i_lim,
    input  logic                     i_hold,
    output logic signed [VEL_W-1:0]  o_vel
);

    localparam int MIX_W = TERM_W + 2;

    logic signed [MIX_W-1:0] pitch_e;
    logic signed [MIX_W-1:0] roll_e;
    logic signed [MIX_W-1:0] total;
    logic signed [MIX_W-1:0] floored;
    logic signed [MIX_W-1:0] lim_p;
    logic signed [MIX_W-1:0] lim_n;
    logic signed [MIX_W-1:0] clamped;

    // Signed mix of the three contributing terms
    assign pitch_e = i_pitch_neg ? -MIX_W'(i_pitch) : MIX_W'(i_pitch);
    assign roll_e  = i_roll_neg  ? -MIX_W'(i_roll)  : MIX_W'(i_roll);
    assign total   = pitch_e + roll_e - MIX_W'(i_pos);

    // Floor to whole units by an arithmetic shift
    assign floored = total >>> FRAC_BITS;

    // Symmetric clamp
    assign lim_p = MIX_W'({1'b0, i_lim});
    assign lim_n = -lim_p;

    always_comb begin
        if (floored > lim_p) begin
            clamped = lim_p;
        end else if (floored < lim_n) begin
            clamped = lim_n;
        end else begin
            clamped = floored;
        end
    end

    // Velocities are forced to zero while the start positions are held
    assign o_vel = i_hold ? '0 : clamped[VEL_W-1:0];

endmodule

// File: src/posture_pid_mixer_top.sv
`timescale 1ns / 1ps
// Pipeline: each accepted item passes the input register, the term register and
// the result register in turn; an output stall can hold them.
// Throughput: one item per cycle unless the output stalls; each PID term has its own multipliers.
// Reset (synchronous, active low) restores the default gains and limits and
// clears the tick counter, the sample history and the running sums.
// ----------------------------------------------------------------------------
// posture_pid_mixer_top: attitude and actuator-position PID with mixing
// Six PID terms from pitch, roll and four offset positions are mixed into
// four clamped actuator velocities, with a start-up hold phase.
// ----------------------------------------------------------------------------
module posture_pid_mixer_top
    import ppm_pkg::*;
#(
    parameter int SUM_BITS       = SUM_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_wdata,
    // Input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [ATT_W-1:0]     i_pitch_mrad,
    input  logic signed [ATT_W-1:0]     i_roll_mrad,
    input  logic signed [POS_IN_W-1:0]  i_raw_pos_a,
    input  logic signed [POS_IN_W-1:0]  i_raw_pos_b,
    input  logic signed [POS_IN_W-1:0]  i_raw_pos_c,
    input  logic signed [POS_IN_W-1:0]  i_raw_pos_d,
    // Output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hold_phase,
    output logic signed [VEL_W-1:0]     o_vel_a,
    output logic signed [VEL_W-1:0]     o_vel_b,
    output logic signed [VEL_W-1:0]     o_vel_c,
    output logic signed [VEL_W-1:0]     o_vel_d
);

    localparam int TERM_W = SUM_BITS + GAIN_W + 3;

    // Configuration registers
    logic [GAIN_W-1:0] r_att_kp, r_att_ki, r_att_kd;
    logic [GAIN_W-1:0] r_pos_kp, r_pos_ki, r_pos_kd;
    logic [TICK_W-1:0] r_hold_ticks;
    logic [LIM_W-1:0]  r_vel_limit;

    // Controller state
    logic [TICK_W-1:0]          r_tick;
    logic signed [X_W-1:0]      r_prev [NTERMS];
    logic signed [SUM_BITS-1:0] r_sum  [NTERMS];

    // Pipeline registers
    logic                       r_s1_valid, r_s1_hold;
    logic signed [X_W-1:0]      r_s1_x [NTERMS];
    logic signed [D_W-1:0]      r_s1_d [NTERMS];
    logic signed [SUM_BITS-1:0] r_s1_s [NTERMS];
    logic                       r_s2_valid, r_s2_hold;
    logic signed [TERM_W-1:0]   r_s2_term [NTERMS];
    logic                       r_out_valid, r_out_hold;
    logic signed [VEL_W-1:0]    r_vel [NPOS];

    // Next values
    logic signed [X_W-1:0]      n_x   [NTERMS];
    logic signed [D_W-1:0]      n_d   [NTERMS];
    logic signed [SUM_BITS-1:0] n_sum [NTERMS];
    logic signed [TERM_W-1:0]   n_term [NTERMS];
    logic signed [VEL_W-1:0]    n_vel [NPOS];
    logic                       n_hold;

    logic adv_out, adv2, adv1, in_accept;

    // ---------------------------------------------------------------- control
    // Each stage moves on when it is empty or its content moves on.
    assign adv_out   = !r_out_valid || !i_out_stall;
    assign adv2      = !r_s2_valid  || adv_out;
    assign adv1      = !r_s1_valid  || adv2;
    assign in_accept = i_in_valid && adv1;
    assign o_in_stall = !adv1;

    // --------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att_kp     <= ATT_KP_RST;
            r_att_ki     <= ATT_KI_RST;
            r_att_kd     <= ATT_KD_RST;
            r_pos_kp     <= POS_KP_RST;
            r_pos_ki     <= POS_KI_RST;
            r_pos_kd     <= POS_KD_RST;
            r_hold_ticks <= HOLD_TICKS_RST;
            r_vel_limit  <= VEL_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ATT_KP:     r_att_kp     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_ATT_KI:     r_att_ki     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_ATT_KD:     r_att_kd     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_POS_KP:     r_pos_kp     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_POS_KI:     r_pos_ki     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_POS_KD:     r_pos_kd     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_HOLD_TICKS: r_hold_ticks <= i_cfg_wdata[TICK_W-1:0];
                CFG_VEL_LIMIT:  r_vel_limit  <= i_cfg_wdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------ sample front end
    // Attitude samples are sign extended; positions have their offsets added.
    always_comb begin
        n_x[0] = X_W'(i_pitch_mrad);
        n_x[1] = X_W'(i_roll_mrad);
        n_x[2] = X_W'(i_raw_pos_a) + POS_OFFSET[0];
        n_x[3] = X_W'(i_raw_pos_b) + POS_OFFSET[1];
        n_x[4] = X_W'(i_raw_pos_c) + POS_OFFSET[2];
        n_x[5] = X_W'(i_raw_pos_d) + POS_OFFSET[3];
    end

    // Difference from the last sample and the saturating running sum
    for (genvar t = 0; t < NTERMS; t++) begin : g_front
        logic signed [SUM_BITS:0] sum_w;

        assign n_d[t] = D_W'(n_x[t]) - D_W'(r_prev[t]);
        assign sum_w  = (SUM_BITS+1)'(r_sum[t]) + (SUM_BITS+1)'(n_x[t]);

        always_comb begin
            if (sum_w[SUM_BITS] != sum_w[SUM_BITS-1]) begin
                n_sum[t] = sum_w[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                           : {1'b0, {(SUM_BITS-1){1'b1}}};
            end else begin
                n_sum[t] = sum_w[SUM_BITS-1:0];
            end
        end
    end

    assign n_hold = (r_tick <= r_hold_ticks);

    // State update and input register, once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_s1_valid <= 1'b0;
            for (int t = 0; t < NTERMS; t++) begin
                r_prev[t] <= '0;
                r_sum[t]  <= '0;
            end
        end else begin
            if (adv1) begin
                r_s1_valid <= i_in_valid;
            end
            if (in_accept) begin
                if (r_tick != TICK_MAX) begin
                    r_tick <= r_tick + 1'b1;
                end
                for (int t = 0; t < NTERMS; t++) begin
                    r_prev[t] <= n_x[t];
                    r_sum[t]  <= n_sum[t];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_hold <= n_hold;
            for (int t = 0; t < NTERMS; t++) begin
                r_s1_x[t] <= n_x[t];
                r_s1_d[t] <= n_d[t];
                r_s1_s[t] <= r_sum[t];
            end
        end
    end

    // ------------------------------------------------------------ PID terms
    for (genvar t = 0; t < NTERMS; t++) begin : g_term
        localparam bit IS_ATT = (t < 2);

        ppm_term #(
            .SUM_BITS (SUM_BITS)
        ) u_term (
            .i_kp   (IS_ATT ? r_att_kp : r_pos_kp),
            .i_ki   (IS_ATT ? r_att_ki : r_pos_ki),
            .i_kd   (IS_ATT ? r_att_kd : r_pos_kd),
            .i_x    (r_s1_x[t]),
            .i_d    (r_s1_d[t]),
            .i_s    (r_s1_s[t]),
            .o_term (n_term[t])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_s1_valid) begin
            r_s2_hold <= r_s1_hold;
            for (int t = 0; t < NTERMS; t++) begin
                r_s2_term[t] <= n_term[t];
            end
        end
    end

    // --------------------------------------------------------------- mixing
    // Channel j: +/-pitch, +/-roll, minus its own position term.
    for (genvar j = 0; j < NPOS; j++) begin : g_mix
        localparam bit PITCH_NEG = (j >= 2);
        localparam bit ROLL_NEG  = (j == 0) || (j == 2);

        ppm_mix #(
            .TERM_W    (TERM_W),
            .FRAC_BITS (GAIN_FRAC_BITS)
        ) u_mix (
            .i_pitch     (r_s2_term[0]),
            .i_roll      (r_s2_term[1]),
            .i_pos       (r_s2_term[j+2]),
            .i_pitch_neg (PITCH_NEG),
            .i_roll_neg  (ROLL_NEG),
            .i_lim       (r_vel_limit),
            .i_hold      (r_s2_hold),
            .o_vel       (n_vel[j])
        );
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s2_valid) begin
            r_out_hold <= r_s2_hold;
            for (int j = 0; j < NPOS; j++) begin
                r_vel[j] <= n_vel[j];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hold_phase = r_out_hold;
    assign o_vel_a      = r_vel[0];
    assign o_vel_b      = r_vel[1];
    assign o_vel_c      = r_vel[2];
    assign o_vel_d      = r_vel[3];

    // ----------------------------------------------------------- assertions
    // A result in the hold phase carries zero velocities.
    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hold_phase) |->
            (o_vel_a == '0 && o_vel_b == '0 && o_vel_c == '0 && o_vel_d == '0))
        else $error("velocity not zero during hold phase");

    // Velocities a and d stay within the configured limit.
    a_vel_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_vel_a <= $signed({1'b0, r_vel_limit}) &&
             o_vel_a >= -$signed({1'b0, r_vel_limit}) &&
             o_vel_d <= $signed({1'b0, r_vel_limit}) &&
             o_vel_d >= -$signed({1'b0, r_vel_limit})))
        else $error("velocity outside clamp");

    // The tick counter advances by one per accepted item until it saturates.
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_tick != TICK_MAX) |=> (r_tick == $past(r_tick) + 1'b1))
        else $error("tick counter did not advance");

    // Input is never refused while the input stage is empty.
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid) |-> !o_in_stall)
        else $error("input stalled with an empty input stage");

endmodule
